>>> sv/segment_obstacle_validity_check_macros.svh
// Assertion macros for the segment obstacle validity check.
// Expects signals named clk and rst in the scope of each use.
`ifndef SEGMENT_OBSTACLE_VALIDITY_CHECK_MACROS_SVH
`define SEGMENT_OBSTACLE_VALIDITY_CHECK_MACROS_SVH

// same-cycle implication
`define SOVC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define SOVC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> sv/sovc_pkg.sv
// Types, codes and helpers shared by the segment obstacle validity check.
// No dependencies.
package sovc_pkg;

  localparam int COORD_W = 16;
  localparam int RECT_XY_W = 15;
  localparam int RECT_WH_W = 14;
  localparam int MAP_W = 15;
  localparam int DIFF_W = 17;
  localparam int PROD_W = 34;
  localparam int WIDE_W = 36;
  localparam int CFG_IDX_W = 1;
  localparam logic [MAP_W-1:0] MAP_RESET = 15'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_LIMIT = 1'b0,
    CFG_Y_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_CHECK = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic signed [RECT_XY_W-1:0] x;
    logic signed [RECT_XY_W-1:0] y;
    logic [RECT_WH_W-1:0]        w;
    logic [RECT_WH_W-1:0]        h;
  } rect_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
  } query_t;

  typedef struct packed {
    logic blocked;
    logic crossed;
  } flags_t;

  typedef struct packed {
    logic is_valid;
    logic out_of_map;
    logic point_blocked;
    logic crosses_edge;
    logic table_full;
  } result_t;

  // n/d within 0..1 inclusive, d of zero never counts
  function automatic logic frac_in_unit(input logic signed [WIDE_W-1:0] n,
                                        input logic signed [WIDE_W-1:0] d);
    logic r;
    if (d > 0) begin
      r = (n >= 0) && (n <= d);
    end else if (d < 0) begin
      r = (n <= 0) && (n >= d);
    end else begin
      r = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> sv/sovc_if.sv
// Request and result channel interfaces for the segment obstacle validity check.
// No dependencies.
interface sovc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic signed [14:0] rect_x;
  logic signed [14:0] rect_y;
  logic [13:0] rect_w;
  logic [13:0] rect_h;
  logic signed [15:0] new_x;
  logic signed [15:0] new_y;
  logic signed [15:0] near_x;
  logic signed [15:0] near_y;

  modport source (output valid, req_type, rect_x, rect_y, rect_w, rect_h,
                  new_x, new_y, near_x, near_y, input ready);
  modport sink (input valid, req_type, rect_x, rect_y, rect_w, rect_h,
                new_x, new_y, near_x, near_y, output ready);
endinterface

interface sovc_res_if;
  logic valid;
  logic ready;
  logic is_valid;
  logic out_of_map;
  logic point_blocked;
  logic crosses_edge;
  logic table_full;

  modport source (output valid, is_valid, out_of_map, point_blocked, crosses_edge,
                  table_full, input ready);
  modport sink (input valid, is_valid, out_of_map, point_blocked, crosses_edge,
                table_full, output ready);
endinterface

>>> sv/sovc_cell.sv
// One obstacle cell: holds one rectangle, tests the passing segment against it.
// Depends on sovc_pkg.
module sovc_cell import sovc_pkg::*; (
  input  logic   clk,
  input  logic   wr,
  input  rect_t  wdata,
  input  logic   used,
  input  query_t q_in,
  input  flags_t f_in,
  output query_t q_out,
  output flags_t f_out
);

  rect_t  rect;
  query_t q;

  logic signed [DIFF_W-1:0] l, b, rt, t;
  logic signed [DIFF_W-1:0] nx, ny, cx, cy, dx, dy;
  logic signed [DIFF_W-1:0] ex_l, ex_rt, ey_t, ey_b;
  logic signed [RECT_XY_W-1:0] w_s, h_s;
  logic in_n, in_c;

  logic signed [PROD_W-1:0] p1, p2, p3, p4, p5, p6;
  logic blk, hor_top, hor_bot, ver_l, ver_r;

  logic signed [WIDE_W-1:0] nb_tl, nb_b, nb_r, d_h, d_v;
  logic hit;
  flags_t f;

  always_ff @(posedge clk) begin
    if (wr) begin
      rect <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_in;
  end

  assign l    = {{2{rect.x[RECT_XY_W-1]}}, rect.x};
  assign b    = {{2{rect.y[RECT_XY_W-1]}}, rect.y};
  assign rt   = l + {3'b000, rect.w};
  assign t    = b + {3'b000, rect.h};
  assign nx   = {q.nx[COORD_W-1], q.nx};
  assign ny   = {q.ny[COORD_W-1], q.ny};
  assign cx   = {q.cx[COORD_W-1], q.cx};
  assign cy   = {q.cy[COORD_W-1], q.cy};
  assign dx   = q.dx;
  assign dy   = q.dy;
  assign ex_l  = nx - l;
  assign ex_rt = nx - rt;
  assign ey_t  = ny - t;
  assign ey_b  = ny - b;
  assign w_s  = {1'b0, rect.w};
  assign h_s  = {1'b0, rect.h};
  assign in_n = (nx >= l) && (nx <= rt) && (ny >= b) && (ny <= t);
  assign in_c = (cx >= l) && (cx <= rt) && (cy >= b) && (cy <= t);

  // first stage: products, point containment and narrow edge tests
  always_ff @(posedge clk) begin
    p1      <= dx * ey_t;
    p2      <= dx * ey_b;
    p3      <= dy * ex_l;
    p4      <= dy * ex_rt;
    p5      <= w_s * dy;
    p6      <= h_s * dx;
    blk     <= used && (in_n || in_c);
    hor_top <= used && (rect.w != '0) && frac_in_unit(WIDE_W'(ey_t), -WIDE_W'(dy));
    hor_bot <= used && (rect.w != '0) && frac_in_unit(WIDE_W'(ey_b), -WIDE_W'(dy));
    ver_l   <= used && (rect.h != '0) && frac_in_unit(WIDE_W'(ex_l), -WIDE_W'(dx));
    ver_r   <= used && (rect.h != '0) && frac_in_unit(WIDE_W'(ex_rt), -WIDE_W'(dx));
  end

  // second stage: segment parameter against each edge, merge into the chain
  assign nb_tl = WIDE_W'(p1) - WIDE_W'(p3);
  assign nb_b  = WIDE_W'(p2) - WIDE_W'(p3);
  assign nb_r  = WIDE_W'(p1) - WIDE_W'(p4);
  assign d_h   = -WIDE_W'(p5);
  assign d_v   = -WIDE_W'(p6);
  assign hit = (hor_top && frac_in_unit(nb_tl, d_h)) || (hor_bot && frac_in_unit(nb_b, d_h))
            || (ver_l && frac_in_unit(nb_tl, d_v)) || (ver_r && frac_in_unit(nb_r, d_v));

  always_ff @(posedge clk) begin
    f <= '{blocked: f_in.blocked | blk, crossed: f_in.crossed | hit};
  end

  assign q_out = q;
  assign f_out = f;

endmodule

>>> sv/segment_obstacle_validity_check.sv
// Segment obstacle validity check, top level: control, obstacle count, cell chain.
// Depends on sovc_pkg, sovc_if, sovc_cell and the assertion macro header.
//
// Usage:
//   req carries one request per transfer. An add (req_type 0) stores the rectangle
//   rect_x/rect_y/rect_w/rect_h in the next free cell, or answers table_full when
//   all MAX_OBSTACLES cells are taken. A check (req_type 1) tests new_x/new_y and
//   near_x/near_y against the map bounds and every stored rectangle.
//   res returns exactly one result per request, in order.
//   The configuration port writes the x limit (index 0) or the y limit (index 1).
// Timing:
//   A check streams through the chain of MAX_OBSTACLES cells, one cell per cycle
//   with two stages in each cell; its result is registered when the scan ends, and
//   the next request is taken once that result has been loaded for res.
//   An add goes straight to the hold state, with no scan.
//   One request is in flight at a time; req is taken while res still holds an
//   undelivered result, and a finished result waits while res is stalled.
// Reset:
//   Empties the table, sets both map bounds to 50 and drops any pending result.
`include "segment_obstacle_validity_check_macros.svh"

module segment_obstacle_validity_check import sovc_pkg::*; #(
  parameter int MAX_OBSTACLES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MAP_W-1:0]     cfg_data,
  sovc_req_if.sink             req,
  sovc_res_if.source           res
);

  localparam int CNT_W     = $clog2(MAX_OBSTACLES + 1);
  localparam int SCAN_LAST = MAX_OBSTACLES + 2;
  localparam int SCAN_W    = $clog2(MAX_OBSTACLES + 3);

  state_t state, state_next;
  logic [SCAN_W-1:0] scan_cnt, scan_cnt_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [MAP_W-1:0]  x_limit, y_limit;

  logic    in_ready, req_acc, is_check, full, scan_end, res_load;
  logic    out_valid, out_valid_next;
  result_t hold_res, out_data;
  query_t  qin;
  logic    oom, oom_now;
  rect_t   new_rect;

  logic signed [DIFF_W-1:0] near_x_s, near_y_s, map_w_s, map_h_s;

  query_t q_chain [MAX_OBSTACLES+1];
  flags_t f_chain [MAX_OBSTACLES+1];
  logic [MAX_OBSTACLES-1:0] wr, used;

  assign req_acc  = req.valid && in_ready;
  assign is_check = (req.req_type == REQ_CHECK);
  assign full     = (count == CNT_W'(MAX_OBSTACLES));
  assign req.ready = in_ready;

  assign near_x_s = {req.near_x[COORD_W-1], req.near_x};
  assign near_y_s = {req.near_y[COORD_W-1], req.near_y};
  assign map_w_s  = {2'b00, x_limit};
  assign map_h_s  = {2'b00, y_limit};
  assign oom_now  = !(!req.new_x[COORD_W-1] && (req.new_x != '0)
                   && !req.new_y[COORD_W-1] && (req.new_y != '0)
                   && (near_x_s < map_w_s) && (near_y_s < map_h_s));

  assign new_rect = '{x: req.rect_x, y: req.rect_y, w: req.rect_w, h: req.rect_h};

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit <= MAP_RESET;
      y_limit <= MAP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_X_LIMIT: x_limit <= cfg_data;
        CFG_Y_LIMIT: y_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_acc) begin
          state_next = is_check ? ST_SCAN : ST_HOLD;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == SCAN_W'(SCAN_LAST)) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid || res.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    scan_end = 1'b0;
    res_load = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: scan_end = (scan_cnt == SCAN_W'(SCAN_LAST));
      ST_HOLD: res_load = !out_valid || res.ready;
      default: ;
    endcase
  end

  always_comb begin
    scan_cnt_next = (state == ST_SCAN) ? scan_cnt + 1'b1 : '0;
    count_next = count;
    if (req_acc && !is_check && !full) begin
      count_next = count + 1'b1;
    end
    out_valid_next = out_valid;
    if (res_load) begin
      out_valid_next = 1'b1;
    end else if (res.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_cnt  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      scan_cnt  <= scan_cnt_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (req_acc && is_check) begin
      qin <= '{nx: req.new_x, ny: req.new_y, cx: req.near_x, cy: req.near_y,
               dx: near_x_s - {req.new_x[COORD_W-1], req.new_x},
               dy: near_y_s - {req.new_y[COORD_W-1], req.new_y}};
      oom <= oom_now;
    end
    if (req_acc && !is_check) begin
      hold_res <= '{is_valid: 1'b0, out_of_map: 1'b0, point_blocked: 1'b0,
                    crosses_edge: 1'b0, table_full: full};
    end else if (scan_end) begin
      hold_res <= '{is_valid: !oom && !f_chain[MAX_OBSTACLES].blocked
                              && !f_chain[MAX_OBSTACLES].crossed,
                    out_of_map: oom,
                    point_blocked: f_chain[MAX_OBSTACLES].blocked,
                    crosses_edge: f_chain[MAX_OBSTACLES].crossed,
                    table_full: 1'b0};
    end
    if (res_load) begin
      out_data <= hold_res;
    end
  end

  assign q_chain[0] = qin;
  assign f_chain[0] = '0;

  for (genvar i = 0; i < MAX_OBSTACLES; i++) begin : g_cell
    assign wr[i]   = req_acc && !is_check && !full && (count == CNT_W'(i));
    assign used[i] = (count > CNT_W'(i));

    sovc_cell u_cell (
      .clk   (clk),
      .wr    (wr[i]),
      .wdata (new_rect),
      .used  (used[i]),
      .q_in  (q_chain[i]),
      .f_in  (f_chain[i]),
      .q_out (q_chain[i+1]),
      .f_out (f_chain[i+1])
    );
  end

  assign res.valid         = out_valid;
  assign res.is_valid      = out_data.is_valid;
  assign res.out_of_map    = out_data.out_of_map;
  assign res.point_blocked = out_data.point_blocked;
  assign res.crosses_edge  = out_data.crosses_edge;
  assign res.table_full    = out_data.table_full;

  `SOVC_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(MAX_OBSTACLES))
  `SOVC_ASSERT_NXT(a_full_holds, req_acc && !is_check && full, $stable(count))
  `SOVC_ASSERT_NXT(a_check_scans, req_acc && is_check, state == ST_SCAN && scan_cnt == '0)
  `SOVC_ASSERT_IMP(a_valid_clean, out_valid && out_data.is_valid,
    !out_data.out_of_map && !out_data.point_blocked && !out_data.crosses_edge
    && !out_data.table_full)

endmodule
